@@ design/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int OCOL_W = 7;
  localparam int OROW_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RAW_WR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CELL_W-1:0] ATTR_MASK    = 16'hFF00;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] PRINT_LO     = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI     = 8'h7E;

  typedef struct packed {
    logic accept;
    logic newline_step;
    logic advance;
    logic put_wr;
    logic clear_wr;
    logic move_step;
    logic blank_step;
    logic scan_to_move;
    logic scan_to_blank;
    logic out_load;
    logic out_rd_sel;
    logic out_scrolled;
  } tcw_ctl_t;

  typedef struct packed {
    logic in_put;
    logic in_newline;
    logic in_read;
    logic item_put;
    logic col_last;
    logic row_last;
    logic scan_last;
    logic out_free;
  } tcw_stat_t;

endpackage

`default_nettype wire

@@ design/tcw_ram.sv @@
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ design/tcw_ctrl.sv @@
`default_nettype none

module tcw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire tcw_pkg::tcw_stat_t stat_i,
  output tcw_pkg::tcw_ctl_t      ctl_o
);

  import tcw_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_FINISH = 6'b000100,
    S_MOVE   = 6'b001000,
    S_BLANK  = 6'b010000,
    S_DRAIN  = 6'b100000
  } tcw_state_t;

  tcw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE) && stat_i.out_free;

  always_comb begin
    ctl_o     = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        ctl_o.clear_wr = 1'b1;
        if (stat_i.scan_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid && stat_i.out_free) begin
          ctl_o.accept = 1'b1;
          if (stat_i.in_put && stat_i.in_newline) begin
            ctl_o.newline_step = 1'b1;
            if (stat_i.row_last) begin
              ctl_o.scan_to_move = 1'b1;
              state_nxt = S_MOVE;
            end else begin
              ctl_o.out_load = 1'b1;
            end
          end else if (stat_i.in_put || stat_i.in_read) begin
            state_nxt = S_FINISH;
          end else begin
            ctl_o.out_load = 1'b1;
          end
        end
      end
      S_FINISH: begin
        if (stat_i.item_put) begin
          ctl_o.put_wr  = 1'b1;
          ctl_o.advance = 1'b1;
          if (stat_i.col_last && stat_i.row_last) begin
            ctl_o.scan_to_move = 1'b1;
            state_nxt = S_MOVE;
          end else begin
            ctl_o.out_load = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          ctl_o.out_load   = 1'b1;
          ctl_o.out_rd_sel = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_MOVE: begin
        ctl_o.move_step = 1'b1;
        if (stat_i.scan_last) begin
          ctl_o.scan_to_blank = 1'b1;
          state_nxt = S_BLANK;
        end
      end
      S_BLANK: begin
        ctl_o.blank_step = 1'b1;
        if (stat_i.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        ctl_o.out_load     = 1'b1;
        ctl_o.out_scrolled = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/tcw_datapath.sv @@
`default_nettype none

module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tcw_pkg::tcw_ctl_t             ctl_i,
  output tcw_pkg::tcw_stat_t                 stat_o,
  input  wire logic [tcw_pkg::CMD_W-1:0]     cmd,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  wire logic [tcw_pkg::IDX_W-1:0]     cell_index,
  input  wire logic [tcw_pkg::CELL_W-1:0]    cell_value,
  input  wire logic                          out_tready,
  output logic                               out_tvalid,
  output logic [tcw_pkg::CELL_W-1:0]         read_cell,
  output logic [tcw_pkg::OCOL_W-1:0]         cursor_col,
  output logic [tcw_pkg::OROW_W-1:0]         cursor_row,
  output logic                               scrolled
);

  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] scan_r;
  logic [ADDR_W-1:0] pos_r;
  logic [CHAR_W-1:0] code_r;
  logic              item_put_r;
  logic              in_range_r;
  logic              pend_r;
  logic              pend_blank_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic              out_valid_r;

  logic              col_last, row_last;
  logic              in_range;
  logic [ADDR_W-1:0] pos_in;
  logic [CHAR_W-1:0] code_in;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign col_last = (col_r == COL_W'(COLUMNS - 1));
  assign row_last = (row_r == ROW_W'(ROWS - 1));
  assign in_range = (32'(cell_index) < 32'(CELLS));
  assign pos_in   = base_r + ADDR_W'(col_r);
  assign code_in  = (char_code >= PRINT_LO && char_code <= PRINT_HI) ? char_code : SPACE_CODE;

  assign stat_o.in_put     = (cmd == CMD_PUT);
  assign stat_o.in_newline = (char_code == NEWLINE_CODE);
  assign stat_o.in_read    = (cmd == CMD_READ);
  assign stat_o.item_put   = item_put_r;
  assign stat_o.col_last   = col_last;
  assign stat_o.row_last   = row_last;
  assign stat_o.scan_last  = (scan_r == ADDR_W'(CELLS - 1));
  assign stat_o.out_free   = !out_valid_r || out_tready;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    if (ctl_i.newline_step || (ctl_i.advance && col_last)) begin
      col_nxt = '0;
      if (!row_last) begin
        row_nxt  = row_r + 1'b1;
        base_nxt = base_r + ADDR_W'(COLUMNS);
      end
    end else if (ctl_i.advance) begin
      col_nxt = col_r + 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_r;
    ram_wdata = BLANK_CELL;
    if (ctl_i.clear_wr) begin
      ram_we = 1'b1;
    end else if (pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r;
      ram_wdata = pend_blank_r ? ((ram_rdata & ATTR_MASK) | {8'h00, SPACE_CODE}) : ram_rdata;
    end else if (ctl_i.put_wr) begin
      ram_we    = 1'b1;
      ram_waddr = pos_r;
      ram_wdata = (ram_rdata & ATTR_MASK) | {8'h00, code_r};
    end else if (ctl_i.accept && (cmd == CMD_RAW_WR) && in_range) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(cell_index);
      ram_wdata = cell_value;
    end
  end

  assign ram_raddr = (ctl_i.move_step || ctl_i.blank_step) ? scan_r :
                     (cmd == CMD_PUT) ? pos_in : ADDR_W'(cell_index);

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      base_r      <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      base_r <= base_nxt;
      pend_r <= ctl_i.move_step || ctl_i.blank_step;
      if (ctl_i.scan_to_move) begin
        scan_r <= ADDR_W'(COLUMNS);
      end else if (ctl_i.scan_to_blank) begin
        scan_r <= ADDR_W'(CELLS - COLUMNS);
      end else if (ctl_i.clear_wr || ctl_i.move_step || ctl_i.blank_step) begin
        scan_r <= scan_r + 1'b1;
      end
      if (ctl_i.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.accept) begin
      pos_r      <= pos_in;
      code_r     <= code_in;
      item_put_r <= (cmd == CMD_PUT);
      in_range_r <= in_range;
    end
    pend_blank_r <= ctl_i.blank_step;
    pend_addr_r  <= ctl_i.blank_step ? scan_r : scan_r - ADDR_W'(COLUMNS);
    if (ctl_i.out_load) begin
      read_cell  <= (ctl_i.out_rd_sel && in_range_r) ? ram_rdata : '0;
      cursor_col <= OCOL_W'(col_nxt);
      cursor_row <= OROW_W'(row_nxt);
      scrolled   <= ctl_i.out_scrolled;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

@@ design/text_console_writer.sv @@
// Text console writer over a COLUMNS x ROWS screen of 16-bit cells, attribute
// in the high byte and character in the low byte, with a hidden cursor.
// Each transaction on the in_ channel carries a command in in_tuser: put a
// character at the cursor, write a raw cell, or read a cell. Each command
// yields exactly one transaction on the out_ channel with the read data, the
// cursor position after the command and a flag that is set when the command
// scrolled the screen.
// Raw writes, newlines without a scroll and the unused command answer in the
// cycle after acceptance and, while out_tready is high, can be accepted back
// to back, one per cycle. Any other put, and a read, goes through S_FINISH,
// since the single read port of the cell memory is registered and a put reads
// the cell before the write back; the input is held off meanwhile.
// A put that moves past the last row scrolls the screen; the copy walks the
// memory one cell per cycle, moving the rows up and then blanking the
// characters of the last row, and the answer follows the copy.
// After reset the cell memory is filled with blank grey spaces, one cell per
// cycle, so in_tready stays low until every cell is cleared.
// A new item is taken only when the output register is empty or is being
// emptied in the same cycle, so a stalled receiver holds off the input side.
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // char_code, cell_index, cell_value
  input  wire logic [1:0]  in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // read_cell, cursor_col, cursor_row, scrolled
);

  import tcw_pkg::*;

  tcw_ctl_t          ctl;
  tcw_stat_t         stat;
  logic [CELL_W-1:0] read_cell;
  logic [OCOL_W-1:0] cursor_col;
  logic [OROW_W-1:0] cursor_row;
  logic              scrolled;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat_i    (stat),
    .ctl_o     (ctl)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl),
    .stat_o     (stat),
    .cmd        (in_tuser),
    .char_code  (in_tdata[7:0]),
    .cell_index (in_tdata[18:8]),
    .cell_value (in_tdata[34:19]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .read_cell  (read_cell),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (scrolled)
  );

  assign out_tdata = {3'b000, scrolled, cursor_row, cursor_col, read_cell};

  a_accept_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!out_tvalid || out_tready))
    else $error("input accepted while a result is still waiting");

  a_scroll_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[28]) |->
      (out_tdata[27:23] == OROW_W'(ROWS - 1) && out_tdata[15:0] == 16'h0000))
    else $error("scroll result with wrong cursor row or read data");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[27:23]) < ROWS))
    else $error("cursor row beyond the screen");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken before the screen was cleared");

endmodule

`default_nettype wire
